FILE: sv/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared constants, types and window tables for the pulse-distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    localparam int unsigned FRAME_BITS  = 64;
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned DUR_W       = 16;
    localparam int unsigned TOL_W       = 7;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned TOL_MAX     = 100;
    localparam int unsigned TOL_RESET   = 25;
    localparam int unsigned ALIGN_SHIFT = WORD_W - FRAME_BITS;
    localparam int unsigned BIT_CNT_W   = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

    localparam int unsigned HDR_NOM        = 9900;
    localparam int unsigned HDR2_MARK_NOM  = 4600;
    localparam int unsigned HDR2_SPACE_NOM = 2600;
    localparam int unsigned BIT_MARK_NOM   = 330;
    localparam int unsigned BIT_ZERO_NOM   = 400;
    localparam int unsigned BIT_ONE_NOM    = 980;
    localparam int unsigned FOOT_MARK_NOM  = 330;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_HDR  = 2'd1,
        ST_BIT  = 2'd2,
        ST_FOOT = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR1 = 5'b00010,
        S_HDR2 = 5'b00100,
        S_BITS = 5'b01000,
        S_FOOT = 5'b10000
    } t_state;

    typedef struct packed {
        logic hdr;
        logic hdr2;
        logic bit_one;
        logic bit_zero;
        logic foot;
    } t_match;

    typedef logic [DUR_W-1:0] t_bound_tab [0:TOL_MAX];

    function automatic t_bound_tab mk_lo(int unsigned nom);
        t_bound_tab tab;
        for (int unsigned t = 0; t <= TOL_MAX; t++) begin
            tab[t] = DUR_W'(nom * (TOL_MAX - t) / TOL_MAX);
        end
        return tab;
    endfunction

    function automatic t_bound_tab mk_hi(int unsigned nom);
        t_bound_tab tab;
        for (int unsigned t = 0; t <= TOL_MAX; t++) begin
            tab[t] = DUR_W'(nom * (TOL_MAX + t) / TOL_MAX);
        end
        return tab;
    endfunction

    localparam t_bound_tab HDR_LO        = mk_lo(HDR_NOM);
    localparam t_bound_tab HDR_HI        = mk_hi(HDR_NOM);
    localparam t_bound_tab HDR2_MARK_LO  = mk_lo(HDR2_MARK_NOM);
    localparam t_bound_tab HDR2_MARK_HI  = mk_hi(HDR2_MARK_NOM);
    localparam t_bound_tab HDR2_SPACE_LO = mk_lo(HDR2_SPACE_NOM);
    localparam t_bound_tab HDR2_SPACE_HI = mk_hi(HDR2_SPACE_NOM);
    localparam t_bound_tab BIT_MARK_LO   = mk_lo(BIT_MARK_NOM);
    localparam t_bound_tab BIT_MARK_HI   = mk_hi(BIT_MARK_NOM);
    localparam t_bound_tab BIT_ZERO_LO   = mk_lo(BIT_ZERO_NOM);
    localparam t_bound_tab BIT_ZERO_HI   = mk_hi(BIT_ZERO_NOM);
    localparam t_bound_tab BIT_ONE_LO    = mk_lo(BIT_ONE_NOM);
    localparam t_bound_tab BIT_ONE_HI    = mk_hi(BIT_ONE_NOM);
    localparam t_bound_tab FOOT_MARK_LO  = mk_lo(FOOT_MARK_NOM);
    localparam t_bound_tab FOOT_MARK_HI  = mk_hi(FOOT_MARK_NOM);

    function automatic logic in_win(logic [DUR_W-1:0] d, logic [DUR_W-1:0] lo,
                                    logic [DUR_W-1:0] hi);
        return (d >= lo) && (d <= hi);
    endfunction

endpackage

FILE: sv/irpd_if.sv
// ----------------------------------------------------------------------------
// irpd_if
// Valid/ready channels of the pulse-distance decoder.
// ----------------------------------------------------------------------------
interface irpd_pulse_if;
    import irpd_pkg::*;
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] mark_us;
    logic [DUR_W-1:0] space_us;
    modport source (output valid, output mark_us, output space_us, input ready);
    modport sink   (input valid, input mark_us, input space_us, output ready);
endinterface

interface irpd_frame_if;
    import irpd_pkg::*;
    logic                valid;
    logic                ready;
    logic [WORD_W-1:0]   frame_word;
    logic [STATUS_W-1:0] status;
    modport source (output valid, output frame_word, output status, input ready);
    modport sink   (input valid, input frame_word, input status, output ready);
endinterface

interface irpd_cfg_if;
    import irpd_pkg::*;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] tolerance_pct;
    modport source (output valid, output tolerance_pct, input ready);
    modport sink   (input valid, input tolerance_pct, output ready);
endinterface

FILE: sv/irpd_matcher.sv
// ----------------------------------------------------------------------------
// irpd_matcher
// Tolerance window compares of one mark/space pair against every nominal.
// ----------------------------------------------------------------------------
module irpd_matcher
    import irpd_pkg::*;
(
    input  logic [TOL_W-1:0] i_tol,
    input  logic [DUR_W-1:0] i_mark,
    input  logic [DUR_W-1:0] i_space,
    output t_match           o_match
);

    logic [TOL_W-1:0] tol_idx;
    logic             bit_mark_ok;

    assign tol_idx = (i_tol > TOL_W'(TOL_MAX)) ? TOL_W'(TOL_MAX) : i_tol;

    assign bit_mark_ok = in_win(i_mark, BIT_MARK_LO[tol_idx], BIT_MARK_HI[tol_idx]);

    always_comb begin
        o_match.hdr      = in_win(i_mark,  HDR_LO[tol_idx], HDR_HI[tol_idx])
                        && in_win(i_space, HDR_LO[tol_idx], HDR_HI[tol_idx]);
        o_match.hdr2     = in_win(i_mark,  HDR2_MARK_LO[tol_idx], HDR2_MARK_HI[tol_idx])
                        && in_win(i_space, HDR2_SPACE_LO[tol_idx], HDR2_SPACE_HI[tol_idx]);
        o_match.bit_one  = bit_mark_ok
                        && in_win(i_space, BIT_ONE_LO[tol_idx], BIT_ONE_HI[tol_idx]);
        o_match.bit_zero = bit_mark_ok
                        && in_win(i_space, BIT_ZERO_LO[tol_idx], BIT_ZERO_HI[tol_idx]);
        o_match.foot     = in_win(i_mark, FOOT_MARK_LO[tol_idx], FOOT_MARK_HI[tol_idx]);
    end

endmodule

FILE: sv/ir_pulse_distance_frame_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Infrared pulse-distance frame decoder, one mark/space pair per transaction.
// ----------------------------------------------------------------------------
// Accepts one mark/space pair every clock cycle unless the output is stalled.
// Each pair is held in an input register, matched against the window tables
// for the current tolerance and the frame phase, and any result lands in the
// output register when the pair leaves the input register.
// The frame is two long header
// pairs, a second header pair, 64 bit pairs and a footer mark; a good frame
// gives the word with status ok, a mismatch after the first header gives a
// zero word with the failing phase's status. Pairs that do not match the
// first header while idle are dropped. Tolerance writes take effect on the
// next cycle and must be made while no frame is in progress.
module ir_pulse_distance_frame_decoder
    import irpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    irpd_cfg_if.sink           i_cfg,
    irpd_pulse_if.sink         i_pulse,
    irpd_frame_if.source       o_frame
);

    logic [TOL_W-1:0]     r_tol;
    logic                 r_a_valid;
    logic [DUR_W-1:0]     r_a_mark;
    logic [DUR_W-1:0]     r_a_space;
    t_state               r_state,   n_state;
    logic [BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [WORD_W-1:0]    r_shift,   n_shift;
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_word;
    t_status              r_out_status;

    t_match               match;
    logic                 advance;
    logic                 res_fire;
    logic [WORD_W-1:0]    res_word;
    t_status              res_status;

    assign i_cfg.ready = 1'b1;

    assign advance       = r_a_valid && (!r_out_valid || o_frame.ready);
    assign i_pulse.ready = !r_a_valid || advance;

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_word = r_out_word;
    assign o_frame.status     = r_out_status;

    irpd_matcher u_matcher (
        .i_tol   (r_tol),
        .i_mark  (r_a_mark),
        .i_space (r_a_space),
        .o_match (match)
    );

    always_comb begin
        n_state    = r_state;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        res_fire   = 1'b0;
        res_word   = '0;
        res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (match.hdr) begin
                    n_state = S_HDR1;
                    n_shift = '0;
                end
            end
            S_HDR1: begin
                if (match.hdr) begin
                    n_state = S_HDR2;
                end else begin
                    res_fire   = 1'b1;
                    res_status = ST_HDR;
                end
            end
            S_HDR2: begin
                if (match.hdr2) begin
                    n_state   = S_BITS;
                    n_bit_cnt = '0;
                end else begin
                    res_fire   = 1'b1;
                    res_status = ST_HDR;
                end
            end
            S_BITS: begin
                if (match.bit_one || match.bit_zero) begin
                    n_shift   = {match.bit_one, r_shift[WORD_W-1:1]};
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    if (r_bit_cnt == BIT_CNT_W'(FRAME_BITS - 1)) begin
                        n_state = S_FOOT;
                    end
                end else begin
                    res_fire   = 1'b1;
                    res_status = ST_BIT;
                end
            end
            S_FOOT: begin
                res_fire = 1'b1;
                if (match.foot) begin
                    res_word   = r_shift >> ALIGN_SHIFT;
                    res_status = ST_OK;
                end else begin
                    res_status = ST_FOOT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (res_fire) begin
            n_state = S_IDLE;
            n_shift = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_W'(TOL_RESET);
            r_a_valid   <= 1'b0;
            r_state     <= S_IDLE;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_tol <= i_cfg.tolerance_pct;
            end
            if (i_pulse.ready) begin
                r_a_valid <= i_pulse.valid;
            end
            if (advance) begin
                r_state   <= n_state;
                r_bit_cnt <= n_bit_cnt;
                r_shift   <= n_shift;
            end
            if (advance && res_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pulse.valid && i_pulse.ready) begin
            r_a_mark  <= i_pulse.mark_us;
            r_a_space <= i_pulse.space_us;
        end
        if (advance && res_fire) begin
            r_out_word   <= res_word;
            r_out_status <= res_status;
        end
    end

    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_pulse.ready |-> r_a_valid
    ) else $error("input stalled with empty input register");

    a_error_word_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && (o_frame.status != ST_OK)) |-> (o_frame.frame_word == '0)
    ) else $error("error result carries a nonzero word");

    a_result_returns_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_fire) |=> (r_state == S_IDLE) && (r_shift == '0) && r_out_valid
    ) else $error("result did not return decoder to idle");

endmodule

FILE: tb/irpd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpd_checker
// Watches the tolerance, pulse and frame channels of the pulse-distance
// decoder. Every accepted pair is run through a local model of the decoder
// that tracks the tolerance, the frame phase and the collected bits, and each
// frame it predicts is queued. Every accepted frame is compared field by field
// with the oldest queued one. Mismatches and unexpected frames are counted.
// ----------------------------------------------------------------------------
module irpd_checker
    import irpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    irpd_cfg_if   i_cfg,
    irpd_pulse_if i_pulse,
    irpd_frame_if i_frame,
    output int    o_fail_cnt,
    output int    o_pending
);

    localparam int PH_IDLE = 0;
    localparam int PH_HDR1 = 1;
    localparam int PH_HDR2 = 2;
    localparam int PH_FOOT = 3 + FRAME_BITS;

    typedef struct {
        logic [WORD_W-1:0] frame_word;
        t_status           status;
    } t_frame_exp;

    t_frame_exp        frame_q[$];
    logic [TOL_W-1:0]  tol;
    int                phase;
    logic [WORD_W-1:0] bits_acc;

    function automatic bit fits(logic [DUR_W-1:0] d, int unsigned nom);
        int unsigned tc;
        tc = (tol > TOL_MAX) ? TOL_MAX : tol;
        return (d >= nom * (TOL_MAX - tc) / TOL_MAX) && (d <= nom * (TOL_MAX + tc) / TOL_MAX);
    endfunction

    task automatic decode_pair(input logic [DUR_W-1:0] m, input logic [DUR_W-1:0] s);
        t_frame_exp r;
        bit         emit;
        emit         = 1'b0;
        r.frame_word = '0;
        r.status     = ST_OK;
        if (phase == PH_IDLE) begin
            if (fits(m, HDR_NOM) && fits(s, HDR_NOM)) begin
                phase    = PH_HDR1;
                bits_acc = '0;
            end
        end else if (phase == PH_HDR1) begin
            if (fits(m, HDR_NOM) && fits(s, HDR_NOM)) begin
                phase = PH_HDR2;
            end else begin
                emit     = 1'b1;
                r.status = ST_HDR;
            end
        end else if (phase == PH_HDR2) begin
            if (fits(m, HDR2_MARK_NOM) && fits(s, HDR2_SPACE_NOM)) begin
                phase = phase + 1;
            end else begin
                emit     = 1'b1;
                r.status = ST_HDR;
            end
        end else if (phase < PH_FOOT) begin
            if (fits(m, BIT_MARK_NOM) && fits(s, BIT_ONE_NOM)) begin
                bits_acc = {1'b1, bits_acc[WORD_W-1:1]};
                phase    = phase + 1;
            end else if (fits(m, BIT_MARK_NOM) && fits(s, BIT_ZERO_NOM)) begin
                bits_acc = bits_acc >> 1;
                phase    = phase + 1;
            end else begin
                emit     = 1'b1;
                r.status = ST_BIT;
            end
        end else if (fits(m, FOOT_MARK_NOM)) begin
            emit         = 1'b1;
            r.frame_word = bits_acc >> (WORD_W - FRAME_BITS);
            r.status     = ST_OK;
        end else begin
            emit     = 1'b1;
            r.status = ST_FOOT;
        end
        if (emit) begin
            frame_q.push_back(r);
            phase    = PH_IDLE;
            bits_acc = '0;
        end
    endtask

    task automatic check_frame(input logic [WORD_W-1:0] word, input logic [STATUS_W-1:0] st);
        t_frame_exp e;
        if (frame_q.size() == 0) begin
            $error("unexpected frame: frame_word %h, status %0d", word, st);
            o_fail_cnt++;
        end else begin
            e = frame_q.pop_front();
            if (word !== e.frame_word) begin
                $error("frame_word mismatch: expected %h, actual %h", e.frame_word, word);
                o_fail_cnt++;
            end
            if (st !== e.status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, st);
                o_fail_cnt++;
            end
        end
    endtask

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tol      = TOL_W'(TOL_RESET);
            phase    = PH_IDLE;
            bits_acc = '0;
            frame_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                tol = i_cfg.tolerance_pct;
            end
            if (i_frame.valid && i_frame.ready) begin
                check_frame(i_frame.frame_word, i_frame.status);
            end
            if (i_pulse.valid && i_pulse.ready) begin
                decode_pair(i_pulse.mark_us, i_pulse.space_us);
            end
        end
        o_pending = frame_q.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the infrared pulse-distance frame decoder.
// ----------------------------------------------------------------------------
// Drives a short directed run over the header, bit and window-bound cases,
// then random frames, good and broken at every phase, with idle noise in
// between, under several tolerance settings and three idling patterns on the
// pulse and frame channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import irpd_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n;

    irpd_cfg_if   cfg ();
    irpd_pulse_if pulse ();
    irpd_frame_if frame ();

    int               fail_cnt;
    int               pending;
    int               gap_pct;
    int               stall_pct;
    int               quiet_cycles;
    int               n_items;
    int               n_frames;
    logic [TOL_W-1:0] tol_now;

    ir_pulse_distance_frame_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg),
        .i_pulse (pulse),
        .o_frame (frame)
    );

    irpd_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg      (cfg),
        .i_pulse    (pulse),
        .i_frame    (frame),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk) begin
        frame.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((cfg.valid && cfg.ready) || (pulse.valid && pulse.ready)
            || (frame.valid && frame.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[ir_pulse_distance_frame_decoder] ERROR");
            $finish;
        end
    end

    function automatic int unsigned win_lo(int unsigned nom);
        int unsigned tc;
        tc = (tol_now > TOL_MAX) ? TOL_MAX : tol_now;
        return nom * (TOL_MAX - tc) / TOL_MAX;
    endfunction

    function automatic int unsigned win_hi(int unsigned nom);
        int unsigned tc;
        tc = (tol_now > TOL_MAX) ? TOL_MAX : tol_now;
        return nom * (TOL_MAX + tc) / TOL_MAX;
    endfunction

    function automatic logic [DUR_W-1:0] dur_good(int unsigned nom);
        case ($urandom_range(5))
            0:       return DUR_W'(win_lo(nom));
            1:       return DUR_W'(win_hi(nom));
            2:       return DUR_W'(nom);
            default: return DUR_W'($urandom_range(win_hi(nom), win_lo(nom)));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] dur_bad(int unsigned nom);
        int unsigned lo;
        int unsigned hi;
        lo = win_lo(nom);
        hi = win_hi(nom);
        case ($urandom_range(3))
            0:       return DUR_W'((lo > 0) ? lo - 1 : hi + 1);
            1:       return DUR_W'(hi + 1);
            2:       return DUR_W'((lo > 0) ? $urandom_range(lo - 1, 0)
                                            : $urandom_range(16'hFFFF, hi + 1));
            default: return DUR_W'($urandom_range(16'hFFFF, hi + 1));
        endcase
    endfunction

    task automatic send_pulse(input logic [DUR_W-1:0] m, input logic [DUR_W-1:0] s);
        while ($urandom_range(99) < gap_pct) begin
            pulse.valid <= 1'b0;
            @(negedge clk);
        end
        pulse.valid    <= 1'b1;
        pulse.mark_us  <= m;
        pulse.space_us <= s;
        do @(posedge clk); while (!pulse.ready);
        @(negedge clk);
    endtask

    task automatic drain;
        pulse.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        send_pulse(16'hFFFF, 16'hFFFF);
        drain();
        repeat (4) @(negedge clk);
        cfg.valid         <= 1'b1;
        cfg.tolerance_pct <= v;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        tol_now = v;
    endtask

    task automatic send_bad_pair(input int unsigned mn, input int unsigned sn);
        case ($urandom_range(2))
            0:       send_pulse(dur_bad(mn), dur_good(sn));
            1:       send_pulse(dur_good(mn), dur_bad(sn));
            default: send_pulse(dur_bad(mn), dur_bad(sn));
        endcase
    endtask

    task automatic send_bit(input bit one);
        logic [DUR_W-1:0] s;
        s = one ? dur_good(BIT_ONE_NOM) : dur_good(BIT_ZERO_NOM);
        if (win_lo(BIT_ONE_NOM) <= win_hi(BIT_ZERO_NOM) && $urandom_range(7) == 0) begin
            s = DUR_W'($urandom_range(win_hi(BIT_ZERO_NOM), win_lo(BIT_ONE_NOM)));
        end
        send_pulse(dur_good(BIT_MARK_NOM), s);
    endtask

    task automatic send_bad_bit;
        int unsigned z_lo;
        int unsigned z_hi;
        int unsigned o_lo;
        int unsigned o_hi;
        z_lo = win_lo(BIT_ZERO_NOM);
        z_hi = win_hi(BIT_ZERO_NOM);
        o_lo = win_lo(BIT_ONE_NOM);
        o_hi = win_hi(BIT_ONE_NOM);
        case ($urandom_range(3))
            0: send_pulse(dur_bad(BIT_MARK_NOM), DUR_W'($urandom));
            1: send_pulse(dur_good(BIT_MARK_NOM), DUR_W'($urandom_range(16'hFFFF, o_hi + 1)));
            2: send_pulse(dur_good(BIT_MARK_NOM),
                          DUR_W'((z_lo > 0) ? $urandom_range(z_lo - 1, 0) : o_hi + 1));
            default: send_pulse(dur_good(BIT_MARK_NOM),
                                DUR_W'((z_hi + 1 < o_lo) ? $urandom_range(o_lo - 1, z_hi + 1)
                                                         : o_hi + 1));
        endcase
    endtask

    task automatic send_noise;
        logic [DUR_W-1:0] m;
        logic [DUR_W-1:0] s;
        m = DUR_W'($urandom);
        s = DUR_W'($urandom);
        if (m >= win_lo(HDR_NOM) && m <= win_hi(HDR_NOM)
            && s >= win_lo(HDR_NOM) && s <= win_hi(HDR_NOM)) begin
            m = 16'hFFFF;
        end
        send_pulse(m, s);
    endtask

    // break_at: 0 second long header, 1 second header, 2.. bits, FRAME_BITS+2 footer
    task automatic send_frame;
        int pick;
        int break_at;
        pick = $urandom_range(99);
        if (pick < 30) begin
            break_at = -1;
        end else if (pick < 40) begin
            break_at = 0;
        end else if (pick < 50) begin
            break_at = 1;
        end else if (pick < 85) begin
            break_at = 2 + $urandom_range($urandom_range(FRAME_BITS - 1), 0);
        end else begin
            break_at = FRAME_BITS + 2;
        end
        n_frames++;
        send_pulse(dur_good(HDR_NOM), dur_good(HDR_NOM));
        n_items++;
        for (int p = 0; p <= FRAME_BITS + 2; p++) begin
            n_items++;
            if (p == 0) begin
                if (p == break_at) begin
                    send_bad_pair(HDR_NOM, HDR_NOM);
                    return;
                end
                send_pulse(dur_good(HDR_NOM), dur_good(HDR_NOM));
            end else if (p == 1) begin
                if (p == break_at) begin
                    send_bad_pair(HDR2_MARK_NOM, HDR2_SPACE_NOM);
                    return;
                end
                send_pulse(dur_good(HDR2_MARK_NOM), dur_good(HDR2_SPACE_NOM));
            end else if (p < FRAME_BITS + 2) begin
                if (p == break_at) begin
                    send_bad_bit();
                    return;
                end
                send_bit($urandom_range(1));
            end else if (p == break_at) begin
                send_pulse(dur_bad(FOOT_MARK_NOM), DUR_W'($urandom));
            end else begin
                send_pulse(dur_good(FOOT_MARK_NOM), DUR_W'($urandom));
            end
        end
    endtask

    task automatic run_segment(input int item_goal, input int frame_goal);
        int item_base;
        int frame_base;
        int pick;
        item_base  = n_items;
        frame_base = n_frames;
        while (n_items - item_base < item_goal || n_frames - frame_base < frame_goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(3, 1)) send_noise();
            end else if (pick < 13) begin
                drain();
            end else begin
                send_frame();
            end
        end
    endtask

    initial begin
        rst_n             = 1'b0;
        pulse.valid       = 1'b0;
        pulse.mark_us     = '0;
        pulse.space_us    = '0;
        cfg.valid         = 1'b0;
        cfg.tolerance_pct = '0;
        frame.ready       = 1'b0;
        gap_pct           = 29;
        stall_pct         = 69;
        quiet_cycles      = 0;
        n_items           = 0;
        n_frames          = 0;
        tol_now           = TOL_W'(TOL_RESET);
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_pulse(16'h0000, 16'h0000);
        send_pulse(16'hFFFF, 16'hFFFF);
        send_pulse(DUR_W'(HDR_NOM), DUR_W'(HDR_NOM));
        send_pulse(DUR_W'(win_lo(HDR_NOM) - 1), DUR_W'(HDR_NOM));
        send_pulse(DUR_W'(win_lo(HDR_NOM)), DUR_W'(win_hi(HDR_NOM)));
        send_pulse(DUR_W'(win_hi(HDR_NOM)), DUR_W'(win_lo(HDR_NOM)));
        send_pulse(DUR_W'(HDR2_MARK_NOM), DUR_W'(win_hi(HDR2_SPACE_NOM) + 1));
        send_pulse(DUR_W'(HDR_NOM), DUR_W'(HDR_NOM));
        send_pulse(DUR_W'(HDR_NOM), DUR_W'(HDR_NOM));
        send_pulse(DUR_W'(win_lo(HDR2_MARK_NOM)), DUR_W'(win_lo(HDR2_SPACE_NOM)));
        send_pulse(DUR_W'(BIT_MARK_NOM), DUR_W'(BIT_ONE_NOM));
        send_pulse(DUR_W'(BIT_MARK_NOM), DUR_W'(BIT_ZERO_NOM));
        send_pulse(DUR_W'(win_hi(BIT_MARK_NOM) + 1), DUR_W'(BIT_ZERO_NOM));

        for (int mode = 0; mode < 3; mode++) begin
            gap_pct   = (mode == 0) ? 29 : (mode == 1) ? 69 : 0;
            stall_pct = (mode == 0) ? 69 : (mode == 1) ? 29 : 0;
            for (int k = 0; k < 2; k++) begin
                case (mode)
                    0: if (k == 1) set_tolerance(TOL_W'(0));
                    1: set_tolerance((k == 0) ? TOL_W'(TOL_MAX) : TOL_W'(127));
                    default: set_tolerance((k == 0) ? TOL_W'($urandom_range(99, 42))
                                                    : TOL_W'($urandom_range(41, 1)));
                endcase
                run_segment(160, 8);
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (fail_cnt == 0) begin
            $display("[ir_pulse_distance_frame_decoder] OK");
        end else begin
            $display("[ir_pulse_distance_frame_decoder] ERROR");
        end
        $finish;
    end

endmodule
